FILE: rtl/bbd_pkg.sv
// Shared types and constants for the byte-level BPE token decoder.
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

    localparam int CP_W = 21;

    localparam logic [2:0] STATUS_BYTE      = 3'd0;
    localparam logic [2:0] STATUS_UNMAPPED  = 3'd1;
    localparam logic [2:0] STATUS_BAD_LEAD  = 3'd2;
    localparam logic [2:0] STATUS_MALFORMED = 3'd3;
    localparam logic [2:0] STATUS_RANGE     = 3'd4;

    localparam logic [CP_W-1:0] CP_MAX = 21'h10FFFF;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       token_end;
    } in_item_t;

    typedef struct packed {
        logic [7:0]      out_byte;
        logic [2:0]      status;
        logic [CP_W-1:0] code_point;
        logic            from_token_end;
    } out_item_t;

    typedef struct packed {
        logic [CP_W-1:0] partial;
        logic [1:0]      expected;
        logic            discarding;
    } dec_state_t;

endpackage

`default_nettype wire

FILE: rtl/bbd_map.sv
// Inverse byte-to-unicode table: code point to raw byte.
`timescale 1ns / 1ps
`default_nettype none

module bbd_map
    import bbd_pkg::*;
(
    input  wire logic [CP_W-1:0] code_point,
    output logic                 hit,
    output logic [7:0]           byte_val
);

    logic       low_page;
    logic       self_hit;
    logic       shift_hit;
    logic [6:0] shift_idx;

    assign low_page  = (code_point[CP_W-1:8] == '0);
    assign self_hit  = low_page &&
                       ((code_point[7:0] >= 8'h21 && code_point[7:0] <= 8'h7E) ||
                        (code_point[7:0] >= 8'hA1 && code_point[7:0] <= 8'hAC) ||
                        (code_point[7:0] >= 8'hAE));
    assign shift_hit = (code_point[CP_W-1:9] == '0) && code_point[8] &&
                       (code_point[7:0] <= 8'd67);
    assign shift_idx = code_point[6:0];

    always_comb begin
        hit      = self_hit || shift_hit;
        byte_val = 8'h00;
        if (self_hit) begin
            byte_val = code_point[7:0];
        end else if (shift_hit) begin
            if (shift_idx <= 7'd32) begin
                byte_val = {1'b0, shift_idx};
            end else if (shift_idx <= 7'd66) begin
                byte_val = {1'b0, shift_idx} + 8'd94;
            end else begin
                byte_val = 8'hAD;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bbd_step.sv
// UTF-8 assembly state and per-item decode with result forming.
`timescale 1ns / 1ps
`default_nettype none

module bbd_step
    import bbd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      fire,
    input  wire in_item_t  item,
    output logic           res_valid,
    output out_item_t      res
);

    dec_state_t      state_reg;
    dec_state_t      state_next;
    logic [CP_W-1:0] cont_cp;
    logic [CP_W-1:0] emit_cp;
    logic [1:0]      cont_left;
    logic            map_hit;
    logic [7:0]      map_byte;
    logic [7:0]      b;
    logic            last;

    assign b         = item.in_byte;
    assign last      = item.token_end;
    assign cont_cp   = {state_reg.partial[CP_W-7:0], b[5:0]};
    assign cont_left = state_reg.expected - 2'd1;
    assign emit_cp   = (state_reg.expected != 2'd0) ? cont_cp : {13'd0, b};

    bbd_map u_map (
        .code_point (emit_cp),
        .hit        (map_hit),
        .byte_val   (map_byte)
    );

    always_comb begin
        logic do_emit;
        do_emit    = 1'b0;
        res_valid  = 1'b0;
        res        = '0;
        res.from_token_end = last;
        state_next = state_reg;

        if (state_reg.discarding) begin
            if (last) begin
                state_next = '0;
            end
        end else if (state_reg.expected != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                res_valid  = 1'b1;
                res.status = STATUS_MALFORMED;
                state_next = '0;
                state_next.discarding = !last;
            end else if (cont_left == 2'd0) begin
                do_emit = 1'b1;
            end else if (last) begin
                res_valid  = 1'b1;
                res.status = STATUS_MALFORMED;
                state_next = '0;
            end else begin
                state_next.partial  = cont_cp;
                state_next.expected = cont_left;
            end
        end else if (!b[7]) begin
            do_emit = 1'b1;
        end else if (!b[6] || b[7:3] == 5'b11111) begin
            res_valid  = 1'b1;
            res.status = STATUS_BAD_LEAD;
            state_next = '0;
            state_next.discarding = !last;
        end else if (last) begin
            res_valid  = 1'b1;
            res.status = STATUS_MALFORMED;
            state_next = '0;
        end else if (!b[5]) begin
            state_next.partial  = {16'd0, b[4:0]};
            state_next.expected = 2'd1;
        end else if (!b[4]) begin
            state_next.partial  = {17'd0, b[3:0]};
            state_next.expected = 2'd2;
        end else begin
            state_next.partial  = {18'd0, b[2:0]};
            state_next.expected = 2'd3;
        end

        if (do_emit) begin
            res_valid      = 1'b1;
            res.code_point = emit_cp;
            state_next     = '0;
            if (emit_cp > CP_MAX) begin
                res.status = STATUS_RANGE;
                state_next.discarding = !last;
            end else if (map_hit) begin
                res.status   = STATUS_BYTE;
                res.out_byte = map_byte;
            end else begin
                res.status = STATUS_UNMAPPED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/byte_level_bpe_token_decoder_core.sv
// Top level: input register, decode step and result register.
//
//  port group   dir  payload     handshake
//  s_*          in   in_item_t   s_valid / s_ready
//  m_*          out  out_item_t  m_valid / m_ready
//
// One item per cycle sustained unless the result register stalls; an item's result,
// if any, enters the result register as the item leaves the input register.
// Reset (aresetn, synchronous) clears both valid flags and the decode state.
// A stalled result register holds the item in the input register; s_ready
// stays high whenever the input register drains in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module byte_level_bpe_token_decoder_core
    import bbd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire in_item_t s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output out_item_t     m_item
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      m_valid_reg;
    out_item_t m_item_reg;
    logic      fire;
    logic      res_valid;
    out_item_t res;

    assign fire    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    bbd_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            m_item_reg <= res;
        end
    end

endmodule

`default_nettype wire

FILE: bench/token_decode_checker.sv
// Checker for the BPE token decoder: predicts decoded results and compares them.
`timescale 1ns / 1ps

module token_decode_checker
    import bbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        errors,
    output int        outstanding
);

    logic [CP_W-1:0] cp_acc;
    logic [1:0]      cont_left;
    logic            skipping;
    out_item_t       decoded_q [$];

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    function automatic void flag_error(input logic [2:0] st, input logic [CP_W-1:0] cp,
                                       input logic fin);
        out_item_t r;
        r.out_byte       = 8'h00;
        r.status         = st;
        r.code_point     = cp;
        r.from_token_end = fin;
        decoded_q = {decoded_q, r};
        cp_acc    = '0;
        cont_left = 2'd0;
        skipping  = !fin;
    endfunction

    function automatic void finish_code_point(input logic [CP_W-1:0] cp, input logic fin);
        out_item_t r;
        int        idx;
        if (cp > CP_MAX) begin
            flag_error(STATUS_RANGE, cp, fin);
            return;
        end
        r.code_point     = cp;
        r.from_token_end = fin;
        r.status         = STATUS_BYTE;
        if ((cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
            (cp >= 21'hAE && cp <= 21'hFF)) begin
            r.out_byte = cp[7:0];
        end else if (cp >= 21'd256 && cp <= 21'd323) begin
            idx = int'(cp) - 256;
            if (idx <= 32) begin
                r.out_byte = 8'(idx);
            end else if (idx <= 66) begin
                r.out_byte = 8'(idx - 33 + 'h7F);
            end else begin
                r.out_byte = 8'hAD;
            end
        end else begin
            r.out_byte = 8'h00;
            r.status   = STATUS_UNMAPPED;
        end
        decoded_q = {decoded_q, r};
        cp_acc    = '0;
        cont_left = 2'd0;
    endfunction

    function automatic void decode_byte(input in_item_t it);
        logic [7:0] b;
        logic       fin;
        b   = it.in_byte;
        fin = it.token_end;
        if (skipping) begin
            if (fin) begin
                skipping = 1'b0;
            end
            return;
        end
        if (cont_left != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                flag_error(STATUS_MALFORMED, '0, fin);
                return;
            end
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                finish_code_point(cp_acc, fin);
            end else if (fin) begin
                flag_error(STATUS_MALFORMED, '0, fin);
            end
            return;
        end
        if (!b[7]) begin
            finish_code_point({13'd0, b}, fin);
            return;
        end
        if (!b[6] || b[7:3] == 5'b11111) begin
            flag_error(STATUS_BAD_LEAD, '0, fin);
            return;
        end
        if (!b[5]) begin
            cp_acc    = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end else if (!b[4]) begin
            cp_acc    = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end else begin
            cp_acc    = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end
        if (fin) begin
            flag_error(STATUS_MALFORMED, '0, fin);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            cp_acc    = '0;
            cont_left = 2'd0;
            skipping  = 1'b0;
            decoded_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected item, code point", int'(m_item.code_point), 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_item.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(m_item.out_byte), int'(want.out_byte));
                    if (m_item.status !== want.status)
                        report_mismatch("status", int'(m_item.status), int'(want.status));
                    if (m_item.code_point !== want.code_point)
                        report_mismatch("code_point", int'(m_item.code_point),
                                        int'(want.code_point));
                    if (m_item.from_token_end !== want.from_token_end)
                        report_mismatch("from_token_end", int'(m_item.from_token_end),
                                        int'(want.from_token_end));
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_item);
            end
        end
        outstanding = decoded_q.size();
    end

endmodule

FILE: bench/tb_byte_level_bpe_token_decoder_core.sv
// Testbench top: token byte stimulus, flow control and verdict for the decoder core.
`timescale 1ns / 1ps

module tb_byte_level_bpe_token_decoder_core;
    import bbd_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int TARGET_ITEMS = 950;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    int errors;
    int pending;
    int sent;
    int idle_cycles = 0;
    bit quiet       = 1'b0;
    bit stall_now   = 1'b0;
    bit stall_done  = 1'b0;

    // {token_end, byte}
    logic [8:0] directed_items [0:25] = '{
        {1'b1, 8'h41},
        {1'b1, 8'h00},
        {1'b1, 8'h7F},
        {1'b0, 8'hC4}, {1'b1, 8'h80},
        {1'b0, 8'hC5}, {1'b1, 8'h83},
        {1'b1, 8'h80},
        {1'b0, 8'hFF}, {1'b1, 8'h41},
        {1'b0, 8'hE0}, {1'b1, 8'h41},
        {1'b1, 8'hC3},
        {1'b0, 8'hF7}, {1'b0, 8'hBF}, {1'b0, 8'hBF}, {1'b1, 8'hBF},
        {1'b0, 8'hF0}, {1'b0, 8'h90}, {1'b0, 8'h80}, {1'b1, 8'h80},
        {1'b0, 8'hE2}, {1'b1, 8'h82},
        {1'b0, 8'hED}, {1'b0, 8'hA0}, {1'b1, 8'h80}
    };

    always #4 aclk = ~aclk;

    byte_level_bpe_token_decoder_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    token_decode_checker chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item),
        .errors      (errors),
        .outstanding (pending)
    );

    task automatic push_byte(input logic [7:0] b, input logic fin);
        s_item  <= '{in_byte: b, token_end: fin};
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (!quiet && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    initial begin
        logic [7:0]      tok [$];
        logic [CP_W-1:0] cp;
        int              len;
        int              sel;
        int              cut;
        int              bad_at;
        bit              noisy;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_item  <= '0;
        m_ready <= 1'b0;
        sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_items[i]) begin
            push_byte(directed_items[i][7:0], directed_items[i][8]);
        end
        while (sent < TARGET_ITEMS) begin
            quiet = (sent >= 300 && sent < 450);
            if (!stall_done && sent >= 550) begin
                stall_now  = 1'b1;
                stall_done = 1'b1;
            end
            tok.delete();
            bad_at = -1;
            noisy  = ($urandom_range(0, 9) == 0);
            if (noisy) begin
                repeat ($urandom_range(1, 6)) tok = {tok, 8'($urandom)};
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    sel = $urandom_range(0, 99);
                    if (sel < 35)      cp = 21'($urandom_range(0, 'hFF));
                    else if (sel < 70) cp = 21'($urandom_range(256, 323));
                    else if (sel < 80) cp = 21'($urandom_range(0, 'h7FF));
                    else if (sel < 90) cp = 21'($urandom_range(0, 'h10FFFF));
                    else               cp = 21'($urandom_range('h110000, 'h1FFFFF));
                    len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
                    if (len < 4 && $urandom_range(0, 9) == 0) len++;
                    case (len)
                        1: tok = {tok, {1'b0, cp[6:0]}};
                        2: begin
                            tok = {tok, {3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
                        end
                        3: begin
                            tok = {tok, {4'b1110, cp[15:12]}, {2'b10, cp[11:6]},
                                   {2'b10, cp[5:0]}};
                        end
                        default: begin
                            tok = {tok, {5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                                   {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
                        end
                    endcase
                end
                sel = $urandom_range(0, 99);
                if (sel < 6 && tok.size() > 1) begin
                    cut = $urandom_range(1, tok.size() - 1);
                    tok = tok[0:cut-1];
                end else if (sel < 12) begin
                    bad_at = $urandom_range(0, tok.size() - 1);
                    tok[bad_at][7:6] = (tok[bad_at][7:6] == 2'b10) ? 2'b11 : 2'b10;
                end
            end
            foreach (tok[i]) begin
                push_byte(tok[i], (i == tok.size() - 1) ||
                                  (noisy && $urandom_range(0, 7) == 0));
                if (bad_at < 0 || i <= bad_at) sent++;
            end
        end
        s_valid <= 1'b0;
        quiet = 1'b1;
        wait (pending == 0);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("byte_level_bpe_token_decoder_core regression: pass");
        end else begin
            $display("byte_level_bpe_token_decoder_core regression: fail");
        end
        $finish;
    end

    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (stall_now) begin
                m_ready <= 1'b0;
                repeat (64) @(posedge aclk);
                stall_now = 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("byte_level_bpe_token_decoder_core regression: fail");
            $finish;
        end
    end

endmodule
